// ===== design/sstf_request_queue_top_macros.svh =====
// ----------------------------------------------------------------------------
// sstf_request_queue_top_macros.svh
// Assertion macros shared by the request queue RTL.
// ----------------------------------------------------------------------------
`ifndef SSTF_REQUEST_QUEUE_TOP_MACROS_SVH
`define SSTF_REQUEST_QUEUE_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define SSTF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define SSTF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sstf_pkg.sv =====
// ----------------------------------------------------------------------------
// sstf_pkg
// Types and constants of the seek-ordered request queue.
// ----------------------------------------------------------------------------
package sstf_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SECTOR_W    = 48;
    localparam int TAG_W       = 8;
    localparam int OCC_W       = 6;
    localparam int ENTRY_W     = SECTOR_W + TAG_W;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_NOP      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_WALK = 2'd1,
        S_DONE = 2'd2
    } state_t;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2
    } mode_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
    } entry_t;

    typedef struct packed {
        op_t                 operation;
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
        logic [SECTOR_W-1:0] head_sector;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic                out_valid;
        logic [SECTOR_W-1:0] out_sector;
        logic [TAG_W-1:0]    out_tag;
        logic [OCC_W-1:0]    occupancy;
    } rsp_t;

endpackage

// ===== design/sstf_if.sv =====
// ----------------------------------------------------------------------------
// sstf_req_if / sstf_rsp_if
// Valid/ready channels for queue operations and their results.
// ----------------------------------------------------------------------------
interface sstf_req_if;
    import sstf_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sstf_rsp_if;
    import sstf_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/sstf_ram.sv =====
// ----------------------------------------------------------------------------
// sstf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sstf_ram #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 56,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/sstf_request_queue_top.sv =====
// ----------------------------------------------------------------------------
// sstf_request_queue_top
// Seek-ordered disk request queue with insert, dispatch and remove by tag.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | handshake
//  --------+-----+------------------------------------------------+----------
//  req     | in  | operation, sector, tag, head_sector            | valid/ready
//  rsp     | out | status, out_valid, out_sector, out_tag, occupancy | valid/ready
//
//  Insert, dispatch and remove walk the n queued entries through the RAM read
//  port in a single forward pass. Insert into a full queue, any operation on an
//  empty queue and no-op codes skip the walk and go straight to completion.
//  The walk is bounded by the one read and one write port of the entry RAM.
//  Reset clears the control state and the entry count, not the RAM; RAM contents are never read unwritten.
//  A result held in the output register stalls only the S_DONE completion step.
// ----------------------------------------------------------------------------
`include "sstf_request_queue_top_macros.svh"

module sstf_request_queue_top (
    input  logic       clk,
    input  logic       rst_n,
    sstf_req_if.sink   req,
    sstf_rsp_if.source rsp
);
    import sstf_pkg::*;

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_start;
    status_t             fixed_status_reg, status_start;
    logic                walk_start;
    logic [SECTOR_W-1:0] sec_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic                is_dispatch_reg;
    logic [SECTOR_W-1:0] ref_reg;

    logic [CNT_W-1:0]    count_reg, count_after;
    logic [CNT_W-1:0]    rd_idx_reg;

    logic                s1_valid_reg;
    logic [IDX_W-1:0]    s1_idx_reg;
    logic                s2_valid_reg;
    logic [IDX_W-1:0]    s2_idx_reg;
    entry_t              s2_entry_reg;
    logic [SECTOR_W-1:0] s2_span_new_reg, s2_span_ent_reg;

    logic                found_reg;
    entry_t              carry_reg;
    entry_t              hit_reg;
    entry_t              new_entry;
    logic                ins_hit, del_hit, walk_last;

    logic                rsp_valid_reg;
    rsp_t                rsp_payload_reg;
    logic                rsp_load;
    logic                dispatched;

    logic                rd_en, wr_en;
    logic [IDX_W-1:0]    rd_addr, wr_addr;
    logic [ENTRY_W-1:0]  wr_data, rd_data;
    entry_t              rd_entry;

    function automatic logic [SECTOR_W-1:0] span(input logic [SECTOR_W-1:0] a,
                                                 input logic [SECTOR_W-1:0] b);
        logic [SECTOR_W:0] d;
        begin
            d = {1'b0, a} - {1'b0, b};
            span = d[SECTOR_W] ? (b - a) : d[SECTOR_W-1:0];
        end
    endfunction

    sstf_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry         = rd_data;
    assign new_entry.sector = sec_reg;
    assign new_entry.tag    = tag_reg;
    assign dispatched       = (mode_reg == MODE_DELETE) && found_reg && is_dispatch_reg;

    assign ins_hit   = !found_reg && (s2_span_new_reg <= s2_span_ent_reg);
    assign del_hit   = !found_reg && (is_dispatch_reg ? (s2_idx_reg == '0)
                                                      : (s2_entry_reg.tag == tag_reg));
    assign walk_last = s2_valid_reg
                       && (CNT_W'(s2_idx_reg) == count_reg - CNT_W'(1));

    // operation decode at acceptance
    always_comb
    begin
        mode_start   = MODE_NONE;
        status_start = STAT_OK;
        walk_start   = 1'b0;
        unique case (req.payload.operation) inside
            OP_INSERT:
            begin
                if (count_reg >= CNT_W'(QUEUE_DEPTH))
                begin
                    status_start = STAT_FULL;
                end
                else
                begin
                    mode_start = MODE_INSERT;
                    walk_start = (count_reg != '0);
                end
            end
            OP_DISPATCH, OP_REMOVE:
            begin
                if (count_reg == '0)
                begin
                    status_start = (req.payload.operation == OP_DISPATCH) ? STAT_EMPTY
                                                                          : STAT_NOTFOUND;
                end
                else
                begin
                    mode_start = MODE_DELETE;
                    walk_start = 1'b1;
                end
            end
            default:
            begin
                status_start = STAT_OK;
            end
        endcase
    end

    always_comb
    begin
        count_after = count_reg;
        if (mode_reg == MODE_INSERT)
        begin
            count_after = count_reg + CNT_W'(1);
        end
        else if (mode_reg == MODE_DELETE && found_reg)
        begin
            count_after = count_reg - CNT_W'(1);
        end
    end

    // Reads run at least two entries ahead of the write-back, so the walk
    // never reads an entry it has already rewritten.
    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = rd_idx_reg[IDX_W-1:0];
        wr_en      = 1'b0;
        wr_addr    = s2_idx_reg;
        wr_data    = new_entry;
        rsp_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = walk_start ? S_WALK : S_DONE;
                end
            end
            S_WALK:
            begin
                rd_en = (rd_idx_reg < count_reg);
                if (s2_valid_reg)
                begin
                    if (mode_reg == MODE_INSERT)
                    begin
                        if (ins_hit)
                        begin
                            wr_en = 1'b1;
                        end
                        else if (found_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_data = carry_reg;
                        end
                    end
                    else if (found_reg)
                    begin
                        // close the gap left by the deleted entry
                        wr_en   = 1'b1;
                        wr_addr = s2_idx_reg - IDX_W'(1);
                        wr_data = s2_entry_reg;
                    end
                end
                if (walk_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                    if (mode_reg == MODE_INSERT)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = count_reg[IDX_W-1:0];
                        wr_data = found_reg ? carry_reg : new_entry;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            mode_reg      <= MODE_NONE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= rd_en;
            s2_valid_reg <= s1_valid_reg;
            if (rd_en)
            begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end
            if (req.valid && req.ready)
            begin
                mode_reg   <= mode_start;
                rd_idx_reg <= '0;
                found_reg  <= 1'b0;
            end
            else if (s2_valid_reg && (ins_hit && mode_reg == MODE_INSERT
                                      || del_hit && mode_reg == MODE_DELETE))
            begin
                found_reg <= 1'b1;
            end
            if (rsp_load)
            begin
                count_reg     <= count_after;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            sec_reg          <= req.payload.sector;
            tag_reg          <= req.payload.tag;
            is_dispatch_reg  <= (req.payload.operation == OP_DISPATCH);
            fixed_status_reg <= status_start;
            ref_reg          <= req.payload.head_sector;
        end
        else if (s1_valid_reg)
        begin
            ref_reg <= rd_entry.sector;
        end
        if (s1_valid_reg)
        begin
            s2_idx_reg      <= s1_idx_reg;
            s2_entry_reg    <= rd_entry;
            s2_span_new_reg <= span(sec_reg, ref_reg);
            s2_span_ent_reg <= span(rd_entry.sector, ref_reg);
        end
        if (rd_en)
        begin
            s1_idx_reg <= rd_addr;
        end
        if (s2_valid_reg && (found_reg || ins_hit))
        begin
            carry_reg <= s2_entry_reg;
        end
        if (s2_valid_reg && del_hit)
        begin
            hit_reg <= s2_entry_reg;
        end
        if (rsp_load)
        begin
            rsp_payload_reg.occupancy  <= OCC_W'(count_after);
            rsp_payload_reg.out_valid  <= dispatched;
            rsp_payload_reg.out_sector <= dispatched ? hit_reg.sector : '0;
            rsp_payload_reg.out_tag    <= dispatched ? hit_reg.tag : '0;
            unique case (mode_reg)
                MODE_INSERT:
                begin
                    rsp_payload_reg.status <= STAT_OK;
                end
                MODE_DELETE:
                begin
                    rsp_payload_reg.status <= found_reg ? STAT_OK : STAT_NOTFOUND;
                end
                default:
                begin
                    rsp_payload_reg.status <= fixed_status_reg;
                end
            endcase
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_payload_reg;

    `SSTF_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "entry count exceeds queue depth")
    `SSTF_ASSERT_IMP(a_wr_in_range, clk, rst_n, wr_en, CNT_W'(wr_addr) <= count_reg, "RAM write beyond queue tail")
    `SSTF_ASSERT_IMP(a_rd_in_range, clk, rst_n, rd_en, rd_idx_reg < count_reg, "RAM read beyond queue tail")
    `SSTF_ASSERT_NXT(a_count_on_done, clk, rst_n, !rsp_load, $stable(count_reg), "entry count changed outside completion")

endmodule
